>>> sv/assert_macros.svh
// assertion macros used by the interpolator top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cri_pkg.sv
// package for the catmull-rom interpolator: widths, op codes, divider request and status types
// no dependencies
package cri_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PW = 32;
    localparam int CW = 16;
    localparam int POSW = 22;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic start;
        logic [63:0] numer;
        logic [15:0] denom;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage

>>> sv/cri_divider.sv
// iterative restoring divider, one quotient bit per cycle
// uses cri_pkg
module cri_divider #(
    parameter int QW = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cri_pkg::t_div_req i_req,
    output cri_pkg::t_div_stat o_stat,
    output logic [QW-1:0]     o_quot
);
    import cri_pkg::*;

    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]   r_quot;
    logic [CW:0]     r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_den;
    logic [CW+1:0]   w_trial;
    logic [CW:0]     w_shift;

    assign w_shift = {r_rem[CW-1:0], r_quot[QW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNTW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
                r_quot <= i_req.numer[QW-1:0];
                r_rem  <= '0;
                r_den  <= i_req.denom;
            end else if (r_busy) begin
                if (w_trial[CW+1]) begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[QW-2:0], 1'b0};
                end else begin
                    r_rem  <= w_trial[CW:0];
                    r_quot <= {r_quot[QW-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = r_quot;
endmodule

>>> sv/catmull_rom_interpolator_unit.sv
// catmull-rom interpolator top level: point memory, sequencer, horner datapath
// uses cri_pkg, cri_divider and assert_macros.svh
// append and clear update the point count directly; if points are stored, a query runs the
// serial divide (39-bit with defaults), then per component reads four points, coefficients, 3
// horner steps, saturate; throughput: appends/clears one per cycle while idle with no result
// pending; a query holds the input until its result is taken; reset: count 0, output_count 2
`include "assert_macros.svh"
module catmull_rom_interpolator_unit #(
    parameter int MAX_POINTS = cri_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = cri_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_a[31:0], point_b[63:32], out_index[79:64]
    input  logic [79:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position[21:0], value_a[53:22], value_b[85:54], zero fill
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);
    import cri_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int QW    = NW + CW + FRAC_BITS;
    localparam int SEGW  = QW - FRAC_BITS;
    localparam int ACCW  = 38;
    localparam int PRODW = ACCW + FRAC_BITS + 1;

    localparam logic signed [ACCW-1:0] K2 = ACCW'(2);
    localparam logic signed [ACCW-1:0] K3 = ACCW'(3);
    localparam logic signed [ACCW-1:0] K4 = ACCW'(4);
    localparam logic signed [ACCW-1:0] K5 = ACCW'(5);
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32'sh7fffffff);
    localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_COEF = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_ADD  = 4'd5;
    localparam logic [3:0] ST_FIN  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [2*PW-1:0] r_mem [MAX_POINTS];
    logic [2*PW-1:0] r_rd;

    logic [3:0]      r_st;
    logic [NW-1:0]   r_count;
    logic [CW-1:0]   r_ocnt;
    logic [QW-1:0]   r_pos;
    logic [2:0]      r_k;
    logic            r_rd_vld;
    logic            r_comp;
    logic [1:0]      r_step;
    logic signed [PW-1:0]   r_p [4];
    logic signed [ACCW-1:0] r_cf [3];
    logic signed [ACCW-1:0] r_acc;
    logic signed [PRODW-1:0] r_prod;
    logic signed [PW-1:0] r_va;
    logic signed [PW-1:0] r_vb;
    logic            r_ovld;
    logic [POSW-1:0] r_opos;

    t_div_req        w_req;
    t_div_stat       w_stat;
    logic [QW-1:0]   w_quot;
    logic            w_acc_in;
    logic [CW-1:0]   w_den;
    logic [CW-1:0]   w_idx;
    logic [NW+CW-1:0] w_prod;
    logic [SEGW-1:0] w_seg;
    logic signed [SEGW+2:0] w_ki;
    logic [AW-1:0]   w_kc;
    logic signed [FRAC_BITS:0] w_t;
    logic signed [PW-1:0] w_comp;
    logic signed [ACCW-1:0] w_e [4];
    logic signed [ACCW-1:0] w_half;
    logic signed [PW-1:0]  w_sat;

    assign s_axis_tready = (r_st == ST_IDLE) && !r_ovld;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign w_den = r_ocnt - 1'b1;
    assign w_idx = (s_axis_tdata[79:64] > w_den) ? w_den : s_axis_tdata[79:64];
    assign w_prod = (NW+CW)'(r_count - 1'b1) * (NW+CW)'(w_idx);
    assign w_req.start = w_acc_in && (s_axis_tuser == OP_QUERY) && (r_count != '0);
    assign w_req.numer = 64'(w_prod) << FRAC_BITS;
    assign w_req.denom = w_den;

    cri_divider #(.QW(QW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_stat (w_stat),
        .o_quot (w_quot)
    );

    assign w_seg = r_pos[QW-1:FRAC_BITS];
    assign w_ki  = $signed({3'b000, w_seg}) + $signed((SEGW+3)'(r_k))
                 - $signed((SEGW+3)'(1));
    assign w_kc  = (w_ki < 0) ? '0
                 : (w_ki >= $signed({{(SEGW+3-NW){1'b0}}, r_count}))
                   ? AW'(r_count - 1'b1) : AW'(w_ki);
    assign w_t   = $signed({1'b0, r_pos[FRAC_BITS-1:0]});
    assign w_comp = r_comp ? $signed(r_rd[2*PW-1:PW]) : $signed(r_rd[PW-1:0]);
    assign w_e[0] = ACCW'(r_p[0]);
    assign w_e[1] = ACCW'(r_p[1]);
    assign w_e[2] = ACCW'(r_p[2]);
    assign w_e[3] = ACCW'(r_p[3]);
    assign w_half = r_acc >>> 1;
    assign w_sat = (w_half > SAT_HI) ? 32'sh7fffffff
                 : (w_half < SAT_LO) ? 32'sh80000000 : PW'(w_half);

    // point memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_acc_in && s_axis_tuser == OP_APPEND && r_count < NW'(MAX_POINTS)) begin
            r_mem[AW'(r_count)] <= s_axis_tdata[63:0];
        end
        r_rd <= r_mem[w_kc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_count <= '0;
            r_ocnt  <= 16'd2;
            r_ovld  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ocnt <= i_cfg_data;
            end
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        case (s_axis_tuser)
                            OP_APPEND: begin
                                if (r_count < NW'(MAX_POINTS)) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_CLEAR: r_count <= '0;
                            OP_QUERY: begin
                                r_comp <= 1'b0;
                                r_k    <= '0;
                                if (r_count == '0) begin
                                    r_opos <= '0;
                                    r_va   <= '0;
                                    r_vb   <= '0;
                                    r_ovld <= 1'b1;
                                end else begin
                                    r_st <= ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (w_stat.done) begin
                        r_pos <= (r_ocnt >= 16'd2 && r_count >= NW'(2)) ? w_quot : '0;
                        r_st  <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (r_rd_vld) begin
                        r_p[r_k[1:0] - 2'd1] <= w_comp;
                    end
                    if (r_k == 3'd4) begin
                        r_rd_vld <= 1'b0;
                        if (r_rd_vld) begin
                            r_st <= ST_COEF;
                        end
                    end else begin
                        r_rd_vld  <= 1'b1;
                        r_k       <= r_k + 1'b1;
                    end
                end
                ST_COEF: begin
                    r_acc   <= -w_e[0] + K3 * w_e[1] - K3 * w_e[2] + w_e[3];
                    r_cf[0] <= K2 * w_e[0] - K5 * w_e[1] + K4 * w_e[2] - w_e[3];
                    r_cf[1] <= w_e[2] - w_e[0];
                    r_cf[2] <= K2 * w_e[1];
                    r_step <= '0;
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod <= PRODW'(r_acc) * PRODW'(w_t);
                    r_st <= ST_ADD;
                end
                ST_ADD: begin
                    r_acc <= ACCW'(r_prod >>> FRAC_BITS) + r_cf[r_step];
                    r_step <= r_step + 1'b1;
                    r_st <= (r_step == 2'd2) ? ST_FIN : ST_MUL;
                end
                ST_FIN: begin
                    r_k <= '0;
                    if (!r_comp) begin
                        r_va   <= w_sat;
                        r_comp <= 1'b1;
                        r_st   <= ST_RD;
                    end else begin
                        r_vb <= w_sat;
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_opos <= r_pos[POSW-1:0];
                    r_ovld <= 1'b1;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_vb, r_va, r_opos};

    `CHK_IMPL(a_div_only_in_div, i_clk, i_rst_n, w_stat.busy, r_st == ST_DIV, "divider busy outside divide state")
    `CHK_NEXT(a_count_limit, i_clk, i_rst_n, 1'b1, r_count <= NW'(MAX_POINTS), "point count over capacity")
    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_st != ST_IDLE, !s_axis_tready, "input ready while query runs")
endmodule
